/* rtl/core/efc_pkg.sv */
package efc_pkg;

    localparam int ThrottleW = 12;
    localparam int StepW     = 8;
    localparam int TicksW    = 16;
    localparam int LockW     = 8;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 16;

    localparam logic [ThrottleW-1:0] MinThrottleRst = 12'd1000;
    localparam logic [ThrottleW-1:0] StartSpeedRst  = 12'd1060;
    localparam logic [ThrottleW-1:0] MaxThrottleRst = 12'd2000;
    localparam logic [StepW-1:0]     SpeedStepRst   = 8'd25;
    localparam logic [TicksW-1:0]    DebounceRst    = 16'd50;
    localparam logic [TicksW-1:0]    ArmRst         = 16'd3000;
    localparam logic [LockW-1:0]     LockoutRst     = 8'd5;

    localparam logic [CfgIdxW-1:0] REG_OFF_WIDTH      = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ON_WIDTH       = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_TOP_WIDTH      = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_DETENT_STEP    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_TICKS = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_ARM_TICKS      = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_LOCKOUT_TICKS  = 3'd6;

    typedef struct packed {
        logic [ThrottleW-1:0] off_width;
        logic [ThrottleW-1:0] on_width;
        logic [ThrottleW-1:0] top_width;
        logic [StepW-1:0]     detent_step;
        logic [TicksW-1:0]    debounce_ticks;
        logic [TicksW-1:0]    arm_ticks;
        logic [LockW-1:0]     lockout_ticks;
    } efc_cfg_t;

    typedef struct packed {
        logic button_level;
        logic dir_level;
        logic encoder_edge;
    } efc_tick_t;

    typedef struct packed {
        logic                 pulse_update;
        logic                 armed;
        logic                 fan_on;
        logic [ThrottleW-1:0] throttle_us;
    } efc_result_t;

endpackage

/* rtl/core/efc_cfg.sv */
module efc_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [efc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [efc_pkg::CfgDataW-1:0]  cfg_wdata,
    output efc_pkg::efc_cfg_t             cfg
);
    import efc_pkg::*;

    efc_cfg_t cfg_reg;
    efc_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_OFF_WIDTH:      cfg_next.off_width      = cfg_wdata[ThrottleW-1:0];
                REG_ON_WIDTH:       cfg_next.on_width       = cfg_wdata[ThrottleW-1:0];
                REG_TOP_WIDTH:      cfg_next.top_width      = cfg_wdata[ThrottleW-1:0];
                REG_DETENT_STEP:    cfg_next.detent_step    = cfg_wdata[StepW-1:0];
                REG_DEBOUNCE_TICKS: cfg_next.debounce_ticks = cfg_wdata[TicksW-1:0];
                REG_ARM_TICKS:      cfg_next.arm_ticks      = cfg_wdata[TicksW-1:0];
                REG_LOCKOUT_TICKS:  cfg_next.lockout_ticks  = cfg_wdata[LockW-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.off_width      <= MinThrottleRst;
            cfg_reg.on_width       <= StartSpeedRst;
            cfg_reg.top_width      <= MaxThrottleRst;
            cfg_reg.detent_step    <= SpeedStepRst;
            cfg_reg.debounce_ticks <= DebounceRst;
            cfg_reg.arm_ticks      <= ArmRst;
            cfg_reg.lockout_ticks  <= LockoutRst;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/efc_state.sv */
module efc_state (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_en,
    input  efc_pkg::efc_tick_t     tick,
    input  efc_pkg::efc_cfg_t      cfg,
    output efc_pkg::efc_result_t   result
);
    import efc_pkg::*;

    localparam int SumW = ThrottleW + 2;

    logic [TicksW-1:0]    arm_count_reg, arm_count_next;
    logic                 is_armed_reg, is_armed_next;
    logic [LockW-1:0]     quiet_reg, quiet_next;
    logic [TicksW-1:0]    stable_reg, stable_next;
    logic                 prev_raw_reg, prev_raw_next;
    logic                 deb_level_reg, deb_level_next;
    logic                 fan_reg, fan_next;
    logic [ThrottleW-1:0] target_reg, target_next;
    logic                 sent_valid_reg, sent_valid_next;
    logic [ThrottleW-1:0] sent_reg, sent_next;
    logic                 update;

    logic signed [SumW-1:0] sum;
    logic signed [SumW-1:0] lo_bound;
    logic signed [SumW-1:0] hi_bound;
    logic [ThrottleW-1:0]   clamped;

    always_comb begin
        if (tick.dir_level) begin
            sum = $signed({2'b00, target_reg}) - $signed({{(SumW-StepW){1'b0}}, cfg.detent_step});
        end else begin
            sum = $signed({2'b00, target_reg}) + $signed({{(SumW-StepW){1'b0}}, cfg.detent_step});
        end
        lo_bound = $signed({2'b00, cfg.on_width});
        hi_bound = $signed({2'b00, cfg.top_width});
        priority if (sum < lo_bound) begin
            clamped = cfg.on_width;
        end else if (sum > hi_bound) begin
            clamped = cfg.top_width;
        end else begin
            clamped = sum[ThrottleW-1:0];
        end
    end

    always_comb begin
        arm_count_next  = arm_count_reg;
        is_armed_next   = is_armed_reg;
        prev_raw_next   = prev_raw_reg;
        deb_level_next  = deb_level_reg;
        fan_next        = fan_reg;
        target_next     = target_reg;
        sent_valid_next = sent_valid_reg;
        sent_next       = sent_reg;
        update          = 1'b0;

        quiet_next  = (quiet_reg == {LockW{1'b1}}) ? quiet_reg : quiet_reg + 1'b1;
        stable_next = (stable_reg == {TicksW{1'b1}}) ? stable_reg : stable_reg + 1'b1;

        if (tick.encoder_edge && (quiet_next > cfg.lockout_ticks)) begin
            if (fan_reg) begin
                target_next = clamped;
            end
            quiet_next = '0;
        end

        if (!is_armed_reg) begin
            if (arm_count_reg != {TicksW{1'b1}}) begin
                arm_count_next = arm_count_reg + 1'b1;
            end
            if (arm_count_next >= cfg.arm_ticks) begin
                is_armed_next = 1'b1;
            end
        end else begin
            if (tick.button_level != prev_raw_reg) begin
                stable_next = '0;
            end
            if ((stable_next > cfg.debounce_ticks) && (tick.button_level != deb_level_reg)) begin
                deb_level_next = tick.button_level;
                if (!tick.button_level) begin
                    fan_next    = !fan_reg;
                    target_next = fan_reg ? cfg.off_width : cfg.on_width;
                end
            end
            prev_raw_next = tick.button_level;
            if (!sent_valid_reg || (sent_reg != target_next)) begin
                update          = 1'b1;
                sent_valid_next = 1'b1;
                sent_next       = target_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_count_reg  <= '0;
            is_armed_reg   <= 1'b0;
            quiet_reg      <= '0;
            stable_reg     <= '0;
            prev_raw_reg   <= 1'b1;
            deb_level_reg  <= 1'b1;
            fan_reg        <= 1'b0;
            target_reg     <= MinThrottleRst;
            sent_valid_reg <= 1'b0;
        end else if (step_en) begin
            arm_count_reg  <= arm_count_next;
            is_armed_reg   <= is_armed_next;
            quiet_reg      <= quiet_next;
            stable_reg     <= stable_next;
            prev_raw_reg   <= prev_raw_next;
            deb_level_reg  <= deb_level_next;
            fan_reg        <= fan_next;
            target_reg     <= target_next;
            sent_valid_reg <= sent_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            sent_reg <= sent_next;
        end
    end

    assign result.throttle_us  = target_next;
    assign result.fan_on       = fan_next;
    assign result.armed        = is_armed_next;
    assign result.pulse_update = update;

    a_armed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        is_armed_reg |=> is_armed_reg)
        else $error("armed flag dropped");

    a_fan_needs_arm: assert property (@(posedge aclk) disable iff (!aresetn)
        fan_reg |-> is_armed_reg)
        else $error("fan on while disarmed");

    a_sent_needs_arm: assert property (@(posedge aclk) disable iff (!aresetn)
        sent_valid_reg |-> is_armed_reg)
        else $error("pulse sent while disarmed");

endmodule

/* rtl/core/encoder_fan_throttle_controller_unit.sv */
// Channel  | Ports             | Word
// ---------+-------------------+----------------------------------------------
// tick in  | s_tvalid/s_tready | s_tdata: encoder_edge, dir_level, button_level
// result   | m_tvalid/m_tready | m_tdata: throttle_us, fan_on, armed, pulse_update
// config   | cfg_wr_en         | cfg_index selects the register, cfg_wdata value
//
// Each tick word passes an input register and then the state update into the
// output register.
// One word is accepted every cycle while the result side keeps up.
// A stalled result holds both stages; the input stage still takes a word if empty.
// Reset is synchronous on aresetn and sets defaults but for the data registers.
module encoder_fan_throttle_controller_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // bit 0 encoder_edge, bit 1 dir_level, bit 2 button_level, rest zero
    input  logic [7:0]                    s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // bits 11:0 throttle_us, 12 fan_on, 13 armed, 14 pulse_update, 15 zero
    output logic [15:0]                   m_tdata,
    input  logic                          cfg_wr_en,
    input  logic [efc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [efc_pkg::CfgDataW-1:0]  cfg_wdata
);
    import efc_pkg::*;

    efc_cfg_t    cfg;
    efc_tick_t   tick_reg;
    logic        tick_vld_reg;
    efc_result_t res_reg;
    efc_result_t res_next;
    logic        out_vld_reg;
    logic        advance;
    logic        s_accept;

    assign advance  = tick_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !tick_vld_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    efc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    efc_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .tick    (tick_reg),
        .cfg     (cfg),
        .result  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                tick_vld_reg <= 1'b1;
            end else if (advance) begin
                tick_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            tick_reg <= s_tdata[2:0];
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, res_reg};

    a_update_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.pulse_update) |-> res_reg.armed)
        else $error("update flagged on a disarmed word");

    a_fan_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.fan_on) |-> res_reg.armed)
        else $error("fan on reported while disarmed");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed while stalled");

endmodule
